/* hw/rtl/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, register indexes and the line pattern table for the
// line follower PID drive unit.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int SensorCount   = 6;
   localparam int SampleWidth   = 10;
   localparam int ReqDataWidth  = 64;   // six samples, padded to whole bytes
   localparam int RspDataWidth  = 24;   // two PWMs and the error, padded
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_THRESHOLD  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KP_GAIN    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KI_GAIN    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KD_GAIN    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_BASE_SPEED = 3'd4;

   // register reset values
   localparam logic [9:0]         THRESHOLD_RESET  = 10'd512;
   localparam logic signed [15:0] KP_GAIN_RESET    = 16'sd2560;
   localparam logic signed [15:0] KI_GAIN_RESET    = 16'sd0;
   localparam logic signed [15:0] KD_GAIN_RESET    = 16'sd0;
   localparam logic [7:0]         BASE_SPEED_RESET = 8'd100;

   localparam logic signed [11:0] SUM_LIMIT = 12'sd2047;
   localparam logic [7:0]         PWM_MAX   = 8'd255;

   // known line patterns, leftmost sensor in the top bit
   localparam logic [5:0] PAT_ALL      = 6'b111111;
   localparam logic [5:0] PAT_WIDE     = 6'b011110;
   localparam logic [5:0] PAT_CENTER   = 6'b001100;
   localparam logic [5:0] PAT_LEFT_1   = 6'b001000;
   localparam logic [5:0] PAT_RIGHT_1  = 6'b000100;
   localparam logic [5:0] PAT_LEFT_2   = 6'b011000;
   localparam logic [5:0] PAT_RIGHT_2  = 6'b000110;
   localparam logic [5:0] PAT_LEFT_3   = 6'b010000;
   localparam logic [5:0] PAT_RIGHT_3  = 6'b000010;
   localparam logic [5:0] PAT_LEFT_4   = 6'b110000;
   localparam logic [5:0] PAT_RIGHT_4  = 6'b000011;
   localparam logic [5:0] PAT_LEFT_5   = 6'b100000;
   localparam logic [5:0] PAT_RIGHT_5  = 6'b000001;

   typedef struct packed {
      logic signed [15:0] kp_gain;
      logic signed [15:0] ki_gain;
      logic signed [15:0] kd_gain;
      logic [7:0]         base_speed;
      logic [9:0]         threshold;
   } csr_type;

   typedef struct packed {
      logic               hit;
      logic signed [3:0]  err;
   } map_type;

   typedef struct packed {
      logic signed [3:0]  err;
      logic signed [11:0] sum;
      logic signed [4:0]  diff;
   } err_word_type;

   typedef struct packed {
      logic signed [19:0] p_term;
      logic signed [27:0] i_term;
      logic signed [20:0] d_term;
      logic signed [3:0]  err;
   } prod_word_type;

   typedef struct packed {
      logic [7:0]         left_pwm;
      logic [7:0]         right_pwm;
      logic signed [3:0]  position_error;
   } rsp_word_type;

   function automatic map_type map_pattern(input logic [5:0] pat);
      map_type m;
      m.hit = 1'b1;
      unique case (pat)
         PAT_ALL, PAT_WIDE, PAT_CENTER: m.err = 4'sd0;
         PAT_LEFT_1:  m.err = -4'sd1;
         PAT_RIGHT_1: m.err = 4'sd1;
         PAT_LEFT_2:  m.err = -4'sd2;
         PAT_RIGHT_2: m.err = 4'sd2;
         PAT_LEFT_3:  m.err = -4'sd3;
         PAT_RIGHT_3: m.err = 4'sd3;
         PAT_LEFT_4:  m.err = -4'sd4;
         PAT_RIGHT_4: m.err = 4'sd4;
         PAT_LEFT_5:  m.err = -4'sd5;
         PAT_RIGHT_5: m.err = 4'sd5;
         default: begin
            m.hit = 1'b0;
            m.err = 4'sd0;
         end
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/lfpd_error_stage.sv */
// ----------------------------------------------------------------------------
// lfpd_error_stage
// Thresholds the samples, looks up the position error and updates the
// saturating error sum and the previous error.
// ----------------------------------------------------------------------------
module lfpd_error_stage (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  logic [lfpd_pkg::SensorCount-1:0][lfpd_pkg::SampleWidth-1:0] samples,
   input  logic [9:0]                                         threshold,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output lfpd_pkg::err_word_type                             out_word
);

   logic [lfpd_pkg::SensorCount-1:0] pattern;
   lfpd_pkg::map_type                map;
   logic signed [3:0]                err;
   logic signed [12:0]               sum_wide;
   logic signed [11:0]               sum_in;
   logic signed [4:0]                diff;
   logic                             accept;

   logic signed [3:0]                last_error_ff;
   logic signed [11:0]               error_sum_ff;
   logic                             valid_ff;
   lfpd_pkg::err_word_type           word_ff;

   always_comb begin
      for (int i = 0; i < lfpd_pkg::SensorCount; i++) begin
         pattern[lfpd_pkg::SensorCount-1-i] = (samples[i] <= threshold);
      end
   end

   assign map = lfpd_pkg::map_pattern(pattern);
   // unknown pattern: keep the previous error
   assign err = map.hit ? map.err : last_error_ff;

   always_comb begin
      sum_wide = {error_sum_ff[11], error_sum_ff} + {{9{err[3]}}, err};
      if (sum_wide > 13'(lfpd_pkg::SUM_LIMIT)) begin
         sum_in = lfpd_pkg::SUM_LIMIT;
      end else if (sum_wide < -13'(lfpd_pkg::SUM_LIMIT)) begin
         sum_in = -lfpd_pkg::SUM_LIMIT;
      end else begin
         sum_in = sum_wide[11:0];
      end
   end

   assign diff     = {err[3], err} - {last_error_ff[3], last_error_ff};
   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            last_error_ff <= err;
            error_sum_ff  <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff.err  <= err;
         word_ff.sum  <= sum_in;
         word_ff.diff <= diff;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* hw/rtl/lfpd_product_stage.sv */
// ----------------------------------------------------------------------------
// lfpd_product_stage
// Forms the three PID products with the Q8.8 gains and registers them.
// ----------------------------------------------------------------------------
module lfpd_product_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lfpd_pkg::err_word_type  in_word,
   input  lfpd_pkg::csr_type       csr,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lfpd_pkg::prod_word_type out_word
);

   logic                    accept;
   logic                    valid_ff;
   lfpd_pkg::prod_word_type word_ff;
   lfpd_pkg::prod_word_type word_in;

   always_comb begin
      word_in.p_term = $signed({{4{csr.kp_gain[15]}}, csr.kp_gain})
                     * $signed({{16{in_word.err[3]}}, in_word.err});
      word_in.i_term = $signed({{12{csr.ki_gain[15]}}, csr.ki_gain})
                     * $signed({{16{in_word.sum[11]}}, in_word.sum});
      word_in.d_term = $signed({{5{csr.kd_gain[15]}}, csr.kd_gain})
                     * $signed({{16{in_word.diff[4]}}, in_word.diff});
      word_in.err    = in_word.err;
   end

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* hw/rtl/lfpd_drive_stage.sv */
// ----------------------------------------------------------------------------
// lfpd_drive_stage
// Sums the PID terms, scales by 1/256 toward zero, applies the correction
// to the base speed and clamps both PWMs. Holds the result word.
// ----------------------------------------------------------------------------
module lfpd_drive_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lfpd_pkg::prod_word_type in_word,
   input  logic [7:0]              base_speed,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lfpd_pkg::rsp_word_type  out_word
);

   logic signed [28:0]     acc;
   logic signed [28:0]     acc_adj;
   logic signed [20:0]     corr;
   logic signed [21:0]     left_wide;
   logic signed [21:0]     right_wide;
   logic                   accept;
   logic                   valid_ff;
   lfpd_pkg::rsp_word_type word_ff;
   lfpd_pkg::rsp_word_type word_in;

   function automatic logic [7:0] clamp_pwm(input logic signed [21:0] v);
      logic [7:0] r;
      if (v < 22'sd0) begin
         r = 8'd0;
      end else if (v > 22'(lfpd_pkg::PWM_MAX)) begin
         r = lfpd_pkg::PWM_MAX;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   always_comb begin
      acc = {{9{in_word.p_term[19]}}, in_word.p_term}
          + {in_word.i_term[27], in_word.i_term}
          + {{8{in_word.d_term[20]}}, in_word.d_term};
      // bias negative sums so the shift truncates toward zero
      acc_adj    = acc + (acc[28] ? 29'sd255 : 29'sd0);
      corr       = acc_adj[28:8];
      left_wide  = $signed({14'd0, base_speed}) - {corr[20], corr};
      right_wide = $signed({14'd0, base_speed}) + {corr[20], corr};
      word_in.left_pwm       = clamp_pwm(left_wide);
      word_in.right_pwm      = clamp_pwm(right_wide);
      word_in.position_error = in_word.err;
   end

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* hw/rtl/line_follower_pid_drive_unit.sv */
// ----------------------------------------------------------------------------
// line_follower_pid_drive_unit
// PID steering for a six-sensor line follower: samples in, two motor PWMs
// and the position error out.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit up)
//  req_      in         sample_0..sample_5 (10 bits each), 4 zero bits
//  rsp_      out        left_pwm 8, right_pwm 8, position_error 4, 4 zero bits
//  csr_      in         csr_index 3 bits, csr_data 16 bits
//
//  One word per cycle in and out while the rsp_ side takes words; each word
//  passes through the error, product and drive registers.
//  Reset clears the error state and the pipeline and loads register defaults.
//  A stalled rsp_ side backs up stage by stage; req_tready drops only when
//  all three stages hold words.
// ----------------------------------------------------------------------------
module line_follower_pid_drive_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lfpd_pkg::ReqDataWidth-1:0]    req_tdata,  // sample_0..sample_5
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lfpd_pkg::RspDataWidth-1:0]    rsp_tdata,  // left, right, error
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lfpd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [lfpd_pkg::CsrDataWidth-1:0]    csr_data
);

   lfpd_pkg::csr_type       csr_ff;
   logic [lfpd_pkg::SensorCount-1:0][lfpd_pkg::SampleWidth-1:0] samples;
   logic                    err_valid;
   logic                    err_ready;
   lfpd_pkg::err_word_type  err_word;
   logic                    prod_valid;
   logic                    prod_ready;
   lfpd_pkg::prod_word_type prod_word;
   lfpd_pkg::rsp_word_type  rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.threshold  <= lfpd_pkg::THRESHOLD_RESET;
         csr_ff.kp_gain    <= lfpd_pkg::KP_GAIN_RESET;
         csr_ff.ki_gain    <= lfpd_pkg::KI_GAIN_RESET;
         csr_ff.kd_gain    <= lfpd_pkg::KD_GAIN_RESET;
         csr_ff.base_speed <= lfpd_pkg::BASE_SPEED_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lfpd_pkg::CSR_THRESHOLD:  csr_ff.threshold  <= csr_data[9:0];
            lfpd_pkg::CSR_KP_GAIN:    csr_ff.kp_gain    <= csr_data;
            lfpd_pkg::CSR_KI_GAIN:    csr_ff.ki_gain    <= csr_data;
            lfpd_pkg::CSR_KD_GAIN:    csr_ff.kd_gain    <= csr_data;
            lfpd_pkg::CSR_BASE_SPEED: csr_ff.base_speed <= csr_data[7:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < lfpd_pkg::SensorCount; i++) begin
         samples[i] = req_tdata[i*lfpd_pkg::SampleWidth +: lfpd_pkg::SampleWidth];
      end
   end

   lfpd_error_stage u_error (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .samples   (samples),
      .threshold (csr_ff.threshold),
      .out_valid (err_valid),
      .out_ready (err_ready),
      .out_word  (err_word)
   );

   lfpd_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_word   (err_word),
      .csr       (csr_ff),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_word  (prod_word)
   );

   lfpd_drive_stage u_drive (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prod_valid),
      .in_ready   (prod_ready),
      .in_word    (prod_word),
      .base_speed (csr_ff.base_speed),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (rsp_word)
   );

   assign rsp_tdata = {4'd0, rsp_word.position_error, rsp_word.right_pwm, rsp_word.left_pwm};

   // input stalls only when every stage is full and the output is blocked
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the pipeline has room");

   a_error_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[19:16]) >= -4'sd5 &&
                      $signed(rsp_tdata[19:16]) <= 4'sd5))
      else $error("position error out of range");

   // the correction moves the two motors in opposite directions
   a_opposite_correction: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[7:0] > csr_ff.base_speed &&
                       rsp_tdata[15:8] > csr_ff.base_speed))
      else $error("both PWMs above base speed");

endmodule

/* sim/line_follower_pid_drive_unit_test.sv */
// ----------------------------------------------------------------------------
// line_follower_pid_drive_unit_test
// Self-checking bench for the line follower PID drive unit. A short table of
// sensor words under the reset settings is checked against typed-in motor
// values. Random phases follow under several register settings, and each of
// them is checked against a cycle-free model of the pattern table, the
// saturating error sum and the clamped drive. Both stream sides idle at
// random, and the result side holds off at times long enough to back the
// block up.
// ----------------------------------------------------------------------------
module line_follower_pid_drive_unit_test;

   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;
   localparam int PAD_LSB     = lfpd_pkg::SensorCount * lfpd_pkg::SampleWidth;

   localparam logic [5:0] LINE_PATTERNS [13] = '{
      lfpd_pkg::PAT_ALL, lfpd_pkg::PAT_WIDE, lfpd_pkg::PAT_CENTER,
      lfpd_pkg::PAT_LEFT_1, lfpd_pkg::PAT_RIGHT_1, lfpd_pkg::PAT_LEFT_2,
      lfpd_pkg::PAT_RIGHT_2, lfpd_pkg::PAT_LEFT_3, lfpd_pkg::PAT_RIGHT_3,
      lfpd_pkg::PAT_LEFT_4, lfpd_pkg::PAT_RIGHT_4,
      lfpd_pkg::PAT_LEFT_5, lfpd_pkg::PAT_RIGHT_5
   };

   typedef enum {DRIFT_NONE, DRIFT_LEFT, DRIFT_RIGHT} drift_type;
   typedef enum {SINK_OPEN, SINK_EVERY_THIRD, SINK_COIN, SINK_MOSTLY} sink_mode_type;

   typedef struct {
      logic [5:0]        pattern;
      logic [9:0]        on_level;
      logic [9:0]        off_level;
      logic [3:0]        pad;
      logic [7:0]        left;
      logic [7:0]        right;
      logic signed [3:0] err;
   } sensor_row_type;

   typedef struct {
      bit                     typed;
      lfpd_pkg::rsp_word_type value;
   } table_rsp_type;

   typedef struct {
      logic [15:0] thr;
      logic [15:0] kp;
      logic [15:0] ki;
      logic [15:0] kd;
      logic [15:0] base;
      drift_type   drift;
      int          count;
      bit          long_stall;
      bit          random_regs;
   } drive_phase_type;

   // reset settings: correction is ten times the error, base speed 100
   sensor_row_type directed_rows [18] = '{
      '{lfpd_pkg::PAT_CENTER,  10'd0,   10'd1023, 4'h0, 8'd100, 8'd100,  4'sd0},
      '{lfpd_pkg::PAT_LEFT_1,  10'd0,   10'd1023, 4'h0, 8'd110, 8'd90,  -4'sd1},
      '{lfpd_pkg::PAT_RIGHT_1, 10'd0,   10'd1023, 4'h0, 8'd90,  8'd110,  4'sd1},
      '{lfpd_pkg::PAT_LEFT_2,  10'd0,   10'd1023, 4'h0, 8'd120, 8'd80,  -4'sd2},
      '{lfpd_pkg::PAT_RIGHT_2, 10'd0,   10'd1023, 4'h0, 8'd80,  8'd120,  4'sd2},
      '{lfpd_pkg::PAT_LEFT_3,  10'd0,   10'd1023, 4'h0, 8'd130, 8'd70,  -4'sd3},
      '{lfpd_pkg::PAT_RIGHT_3, 10'd0,   10'd1023, 4'h0, 8'd70,  8'd130,  4'sd3},
      '{lfpd_pkg::PAT_LEFT_4,  10'd0,   10'd1023, 4'h0, 8'd140, 8'd60,  -4'sd4},
      '{lfpd_pkg::PAT_RIGHT_4, 10'd0,   10'd1023, 4'h0, 8'd60,  8'd140,  4'sd4},
      '{lfpd_pkg::PAT_LEFT_5,  10'd0,   10'd1023, 4'h0, 8'd150, 8'd50,  -4'sd5},
      '{lfpd_pkg::PAT_RIGHT_5, 10'd0,   10'd1023, 4'h0, 8'd50,  8'd150,  4'sd5},
      '{6'b000000,             10'd0,   10'd1023, 4'h0, 8'd50,  8'd150,  4'sd5},
      '{lfpd_pkg::PAT_ALL,     10'd0,   10'd1023, 4'h0, 8'd100, 8'd100,  4'sd0},
      '{lfpd_pkg::PAT_WIDE,    10'd100, 10'd900,  4'h0, 8'd100, 8'd100,  4'sd0},
      '{6'b101010,             10'd0,   10'd1023, 4'h0, 8'd100, 8'd100,  4'sd0},
      '{lfpd_pkg::PAT_LEFT_5,  10'd512, 10'd513,  4'h0, 8'd150, 8'd50,  -4'sd5},
      '{6'b111110,             10'd0,   10'd1023, 4'hF, 8'd150, 8'd50,  -4'sd5},
      '{lfpd_pkg::PAT_RIGHT_5, 10'd512, 10'd1023, 4'hF, 8'd50,  8'd150,  4'sd5}
   };

   drive_phase_type phases [5] = '{
      '{16'd300,   16'sd2560,  16'sd64,     16'sd512,   16'd128,   DRIFT_LEFT,  440, 1'b1, 1'b0},
      '{16'hFFFF,  16'sd32767, -16'sd32768, 16'sd32767, 16'h00FF,  DRIFT_NONE,  30,  1'b0, 1'b0},
      '{16'd0,     -16'sd32768, 16'sd32767, -16'sd32768, 16'd0,    DRIFT_NONE,  30,  1'b0, 1'b0},
      '{16'hFEBC,  16'sd5000,  16'sd10,     -16'sd3000, 16'hFF37,  DRIFT_RIGHT, 772, 1'b1, 1'b0},
      '{16'd0,     16'd0,      16'd0,       16'd0,      16'd0,     DRIFT_NONE,  60,  1'b0, 1'b1}
   };

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [lfpd_pkg::ReqDataWidth-1:0]  req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [lfpd_pkg::RspDataWidth-1:0]  rsp_tdata;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [lfpd_pkg::CsrIndexWidth-1:0] csr_index;
   logic [lfpd_pkg::CsrDataWidth-1:0]  csr_data;

   // model copy of the registers and the error state
   logic [9:0]         cfg_threshold = lfpd_pkg::THRESHOLD_RESET;
   logic signed [15:0] cfg_kp        = lfpd_pkg::KP_GAIN_RESET;
   logic signed [15:0] cfg_ki        = lfpd_pkg::KI_GAIN_RESET;
   logic signed [15:0] cfg_kd        = lfpd_pkg::KD_GAIN_RESET;
   logic [7:0]         cfg_base      = lfpd_pkg::BASE_SPEED_RESET;
   int                 prev_error    = 0;
   int                 error_total   = 0;

   lfpd_pkg::rsp_word_type pending_drive_q [$];
   table_rsp_type          table_rsp_q [$];
   int                     mismatch_count      = 0;
   int                     long_stall_requests = 0;
   int                     burst_left          = 0;

   line_follower_pid_drive_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic lfpd_pkg::rsp_word_type predict_drive(
      input logic [lfpd_pkg::ReqDataWidth-1:0] word);
      logic [5:0]             pat;
      int                     e;
      int                     total;
      int                     diff;
      longint                 acc;
      longint                 corr;
      longint                 left_v;
      longint                 right_v;
      lfpd_pkg::rsp_word_type r;
      pat = '0;
      for (int i = 0; i < lfpd_pkg::SensorCount; i++) begin
         if (word[i*lfpd_pkg::SampleWidth +: lfpd_pkg::SampleWidth] <= cfg_threshold) begin
            pat[lfpd_pkg::SensorCount-1-i] = 1'b1;
         end
      end
      // unknown patterns, all-off among them, hold the previous error
      e = prev_error;
      case (pat)
         lfpd_pkg::PAT_ALL, lfpd_pkg::PAT_WIDE, lfpd_pkg::PAT_CENTER: e = 0;
         lfpd_pkg::PAT_LEFT_1:  e = -1;
         lfpd_pkg::PAT_RIGHT_1: e = 1;
         lfpd_pkg::PAT_LEFT_2:  e = -2;
         lfpd_pkg::PAT_RIGHT_2: e = 2;
         lfpd_pkg::PAT_LEFT_3:  e = -3;
         lfpd_pkg::PAT_RIGHT_3: e = 3;
         lfpd_pkg::PAT_LEFT_4:  e = -4;
         lfpd_pkg::PAT_RIGHT_4: e = 4;
         lfpd_pkg::PAT_LEFT_5:  e = -5;
         lfpd_pkg::PAT_RIGHT_5: e = 5;
         default: ;
      endcase
      total = error_total + e;
      if (total > int'(lfpd_pkg::SUM_LIMIT)) total = int'(lfpd_pkg::SUM_LIMIT);
      if (total < -int'(lfpd_pkg::SUM_LIMIT)) total = -int'(lfpd_pkg::SUM_LIMIT);
      diff = e - prev_error;
      acc = longint'(cfg_kp) * e + longint'(cfg_ki) * total + longint'(cfg_kd) * diff;
      corr = acc / 256;
      error_total = total;
      prev_error = e;
      left_v = longint'(cfg_base) - corr;
      right_v = longint'(cfg_base) + corr;
      if (left_v < 0) left_v = 0;
      if (left_v > longint'(lfpd_pkg::PWM_MAX)) left_v = longint'(lfpd_pkg::PWM_MAX);
      if (right_v < 0) right_v = 0;
      if (right_v > longint'(lfpd_pkg::PWM_MAX)) right_v = longint'(lfpd_pkg::PWM_MAX);
      r.left_pwm = left_v[7:0];
      r.right_pwm = right_v[7:0];
      r.position_error = e[3:0];
      return r;
   endfunction

   // result side first, so a word pushed at this edge is never matched here
   always @(posedge clock) begin
      lfpd_pkg::rsp_word_type want;
      table_rsp_type          hint;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_drive_q.size() == 0) begin
               $display("%0t: result word 0x%06h with no expectation waiting", $time,
                        rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_drive_q.pop_front();
               if (rsp_tdata[7:0] !== want.left_pwm) begin
                  $display("%0t: left_pwm expected %0d got %0d", $time, want.left_pwm,
                           rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[15:8] !== want.right_pwm) begin
                  $display("%0t: right_pwm expected %0d got %0d", $time, want.right_pwm,
                           rsp_tdata[15:8]);
                  mismatch_count++;
               end
               if (rsp_tdata[19:16] !== want.position_error) begin
                  $display("%0t: position_error expected %0d got %0d", $time,
                           want.position_error, $signed(rsp_tdata[19:16]));
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lfpd_pkg::CSR_THRESHOLD:  cfg_threshold = csr_data[9:0];
               lfpd_pkg::CSR_KP_GAIN:    cfg_kp = csr_data;
               lfpd_pkg::CSR_KI_GAIN:    cfg_ki = csr_data;
               lfpd_pkg::CSR_KD_GAIN:    cfg_kd = csr_data;
               lfpd_pkg::CSR_BASE_SPEED: cfg_base = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = predict_drive(req_tdata);
            hint = table_rsp_q.pop_front();
            if (hint.typed) want = hint.value;
            pending_drive_q.push_back(want);
         end
      end
   end

   // result side: changing stall patterns, plus long holds on request
   initial begin
      sink_mode_type mode;
      int            span;
      int            tick;
      int            hold;
      int            served;
      mode = SINK_OPEN;
      span = 0;
      tick = 0;
      hold = 0;
      served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_requests > served) begin
            served++;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = sink_mode_type'($urandom_range(0, 3));
               span = int'($urandom_range(20, 120));
            end
            span--;
            tick++;
            case (mode)
               SINK_OPEN:        rsp_tready <= 1'b1;
               SINK_EVERY_THIRD: rsp_tready <= (tick % 3 == 0);
               SINK_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
               default:          rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic offer_samples(input logic [lfpd_pkg::ReqDataWidth-1:0] word,
                                input table_rsp_type hint);
      bit seen;
      int gap;
      if (burst_left == 0) begin
         gap = int'($urandom_range(0, 12));
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : int'($urandom_range(1, 40));
      end
      burst_left--;
      table_rsp_q.push_back(hint);
      req_tvalid <= 1'b1;
      req_tdata <= word;
      // sample ready at the falling edge ahead of the edge that takes the word
      do begin
         @(negedge clock);
         seen = req_tready;
         @(posedge clock);
      end while (!seen);
   endtask

   task automatic write_csr(input logic [lfpd_pkg::CsrIndexWidth-1:0] idx,
                            input logic [lfpd_pkg::CsrDataWidth-1:0] value);
      bit seen;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         seen = csr_ready;
         @(posedge clock);
      end while (!seen);
   endtask

   task automatic drain_results();
      do @(negedge clock); while (pending_drive_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [lfpd_pkg::ReqDataWidth-1:0]  word;
      logic [lfpd_pkg::CsrIndexWidth-1:0] spare_idx;
      logic [9:0]                         thr;
      logic [5:0]                         pat;
      sensor_row_type                     row;
      drive_phase_type                    ph;
      table_rsp_type                      hint;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         word = '0;
         for (int i = 0; i < lfpd_pkg::SensorCount; i++) begin
            word[i*lfpd_pkg::SampleWidth +: lfpd_pkg::SampleWidth] =
               row.pattern[lfpd_pkg::SensorCount-1-i] ? row.on_level : row.off_level;
         end
         word[lfpd_pkg::ReqDataWidth-1:PAD_LSB] = row.pad;
         hint.typed = 1'b1;
         hint.value.left_pwm = row.left;
         hint.value.right_pwm = row.right;
         hint.value.position_error = row.err;
         offer_samples(word, hint);
      end
      req_tvalid <= 1'b0;
      drain_results();

      hint.typed = 1'b0;
      hint.value = '0;
      foreach (phases[p]) begin
         ph = phases[p];
         if (ph.random_regs) begin
            ph.thr = 16'($urandom);
            ph.kp = 16'($urandom);
            ph.ki = 16'($urandom);
            ph.kd = 16'($urandom);
            ph.base = 16'($urandom);
         end
         write_csr(lfpd_pkg::CSR_THRESHOLD, ph.thr);
         write_csr(lfpd_pkg::CSR_KP_GAIN, ph.kp);
         write_csr(lfpd_pkg::CSR_KI_GAIN, ph.ki);
         write_csr(lfpd_pkg::CSR_KD_GAIN, ph.kd);
         write_csr(lfpd_pkg::CSR_BASE_SPEED, ph.base);
         // indexes past the last register must change nothing
         for (int k = int'(lfpd_pkg::CSR_BASE_SPEED) + 1;
              k < (1 << lfpd_pkg::CsrIndexWidth); k++) begin
            spare_idx = k[lfpd_pkg::CsrIndexWidth-1:0];
            write_csr(spare_idx, 16'($urandom));
         end
         csr_valid <= 1'b0;
         thr = ph.thr[9:0];
         if (ph.long_stall) long_stall_requests++;

         repeat (ph.count) begin
            if (ph.drift != DRIFT_NONE && $urandom_range(0, 99) < 85) begin
               pat = (ph.drift == DRIFT_LEFT) ? lfpd_pkg::PAT_LEFT_5 : lfpd_pkg::PAT_RIGHT_5;
            end else if ($urandom_range(0, 3) == 0) begin
               pat = 6'($urandom);
            end else begin
               pat = LINE_PATTERNS[$urandom_range(0, 12)];
            end
            for (int i = 0; i < lfpd_pkg::SensorCount; i++) begin
               if (pat[lfpd_pkg::SensorCount-1-i] || thr == 10'h3FF) begin
                  word[i*lfpd_pkg::SampleWidth +: lfpd_pkg::SampleWidth] =
                     10'($urandom_range(0, thr));
               end else begin
                  word[i*lfpd_pkg::SampleWidth +: lfpd_pkg::SampleWidth] =
                     10'($urandom_range(int'(thr) + 1, 1023));
               end
            end
            word[lfpd_pkg::ReqDataWidth-1:PAD_LSB] = 4'($urandom);
            if ($urandom_range(0, 15) == 0) word = {$urandom, $urandom};
            offer_samples(word, hint);
         end
         req_tvalid <= 1'b0;
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_error_stage.sv
hw/rtl/lfpd_product_stage.sv
hw/rtl/lfpd_drive_stage.sv
hw/rtl/line_follower_pid_drive_unit.sv
sim/line_follower_pid_drive_unit_test.sv
